FILE: design/height_error_statistics_defines.svh
// assertion macros for the height error statistics rtl
`ifndef HEIGHT_ERROR_STATISTICS_DEFINES_SVH
`define HEIGHT_ERROR_STATISTICS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HES_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("height_error_statistics: check failed");

// next-cycle implication, disabled during reset
`define HES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("height_error_statistics: check failed");

`endif

FILE: design/hes_pkg.sv
// shared widths, codes and types of the height error statistics block
package hes_pkg;

   localparam int HT_W      = 24;
   localparam int ERR_W     = 25;
   localparam int MAG_W     = 25;
   localparam int SQ_W      = 50;
   localparam int SQSUM_W   = 64;
   localparam int RMS_W     = 24;
   localparam int CNT_OUT_W = 17;

   typedef logic signed [ERR_W-1:0] err_type;

   typedef enum logic {
      KIND_POINT   = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   // one classified point travelling from the front to the back
   typedef struct packed {
      err_type           err;
      logic [SQ_W-1:0]   sq;
      logic              valid;
      logic              last;
   } point_type;

endpackage

FILE: design/hes_front.sv
// front end: accepts points, forms the error and its square in two stages
module hes_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [hes_pkg::HT_W-1:0]    req_check_height,
   input  logic signed [hes_pkg::HT_W-1:0]    req_model_height,
   input  logic                               req_model_valid,
   input  logic                               req_last_point,
   input  logic                               req_push,
   output logic                               req_full,
   output logic                               push,
   output hes_pkg::point_type                 push_data,
   input  logic                               fifo_full
);
   import hes_pkg::*;

   logic                 s1_v_ff, s1_v_in;
   err_type              s1_err_ff;
   logic [MAG_W-1:0]     s1_mag_ff;
   logic                 s1_valid_ff, s1_last_ff;
   logic                 s2_v_ff, s2_v_in;
   point_type            s2_pt_ff;
   logic                 s1_ready, s2_ready, accept;
   err_type              diff_a, diff_b;
   logic [SQ_W-1:0]      product;

   // both differences in parallel, the positive one is the magnitude
   assign diff_a = ERR_W'(req_check_height) - ERR_W'(req_model_height);
   assign diff_b = ERR_W'(req_model_height) - ERR_W'(req_check_height);
   assign product = SQ_W'(s1_mag_ff) * SQ_W'(s1_mag_ff);

   // elastic stage control
   assign s2_ready = !s2_v_ff || !fifo_full;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign accept   = req_push && s1_ready;
   assign req_full = !s1_ready;
   assign push      = s2_v_ff && !fifo_full;
   assign push_data = s2_pt_ff;

   always_comb begin
      s1_v_in = s1_v_ff;
      if (accept) begin
         s1_v_in = 1'b1;
      end else if (s2_ready) begin
         s1_v_in = 1'b0;
      end
      s2_v_in = s2_v_ff;
      if (s2_ready) begin
         s2_v_in = s1_v_ff;
      end
   end

   // stage registers, payload without reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
      if (accept) begin
         s1_valid_ff <= req_model_valid;
         s1_last_ff  <= req_last_point;
         s1_err_ff   <= req_model_valid ? diff_a : '0;
         s1_mag_ff   <= !req_model_valid ? '0 : (diff_a[ERR_W-1] ? diff_b : diff_a);
      end
      if (s2_ready && s1_v_ff) begin
         s2_pt_ff.err   <= s1_err_ff;
         s2_pt_ff.sq    <= product;
         s2_pt_ff.valid <= s1_valid_ff;
         s2_pt_ff.last  <= s1_last_ff;
      end
   end

endmodule

FILE: design/hes_fifo.sv
// short queue of classified points between front and back
module hes_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hes_pkg::point_type  push_data,
   output logic                full,
   input  logic                pop,
   output hes_pkg::point_type  pop_data,
   output logic                empty
);
   import hes_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   point_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/hes_summary.sv
// iterative mean and rms unit: two restoring divisions then a bitwise square root
module hes_summary #(
   parameter int CNT_W = 17,
   parameter int SUM_W = 42
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [SUM_W-1:0]              err_sum,
   input  logic [hes_pkg::SQSUM_W-1:0]          sq_sum,
   input  logic [CNT_W-1:0]                     count,
   output logic                                 done,
   output hes_pkg::err_type                     mean,
   output logic [hes_pkg::RMS_W-1:0]            rms
);
   import hes_pkg::*;

   localparam int DIV_STEPS  = SQSUM_W;
   localparam int ROOT_STEPS = SQSUM_W / 2;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int RREM_W     = ROOT_STEPS + 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_DIV_SQ,
      ST_ROOT
   } state_type;

   state_type                 state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [SQSUM_W-1:0]        dvd_ff, dvd_in;
   logic [CNT_W:0]            rem_ff, rem_in;
   logic [SQSUM_W-1:0]        sqsum_ff, sqsum_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   err_type                   mean_ff, mean_in;
   logic [RREM_W-1:0]         rrem_ff, rrem_in;
   logic [ROOT_STEPS-1:0]     root_ff, root_in;
   logic                      done_ff, done_in;

   logic [SUM_W-1:0]          sum_mag;
   logic [CNT_W:0]            rem_sh;
   logic                      q_bit;
   logic [SQSUM_W-1:0]        q_full;
   logic [ERR_W-1:0]          q_low;
   logic [RREM_W-1:0]         rr_sh, trial;
   logic                      r_bit;

   // magnitude of the signed sum, the sign is applied after dividing
   assign sum_mag = err_sum[SUM_W-1] ? SUM_W'(-err_sum) : SUM_W'(err_sum);

   // one restoring division step
   assign rem_sh = {rem_ff[CNT_W-1:0], dvd_ff[SQSUM_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, cnt_ff});
   assign q_full = {dvd_ff[SQSUM_W-2:0], q_bit};
   assign q_low  = q_full[ERR_W-1:0];

   // one square root step, two radicand bits at a time
   assign rr_sh = {rrem_ff[RREM_W-3:0], dvd_ff[SQSUM_W-1:SQSUM_W-2]};
   assign trial = {root_ff, 2'b01};
   assign r_bit = (rr_sh >= trial);

   assign done = done_ff;
   assign mean = mean_ff;
   assign rms  = root_ff[RMS_W-1:0];

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      sqsum_in = sqsum_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      mean_in  = mean_ff;
      rrem_in  = rrem_ff;
      root_in  = root_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dvd_in   = SQSUM_W'(sum_mag);
               neg_in   = err_sum[SUM_W-1];
               sqsum_in = sq_sum;
               cnt_in   = count;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN, ST_DIV_SQ: begin
            rem_in  = q_bit ? rem_sh - {1'b0, cnt_ff} : rem_sh;
            dvd_in  = q_full;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in = '0;
               rem_in  = '0;
               if (state_ff == ST_DIV_MEAN) begin
                  mean_in  = neg_ff ? -q_low : q_low;
                  dvd_in   = sqsum_ff;
                  state_in = ST_DIV_SQ;
               end else begin
                  rrem_in  = '0;
                  root_in  = '0;
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            rrem_in = r_bit ? rr_sh - trial : rr_sh;
            root_in = {root_ff[ROOT_STEPS-2:0], r_bit};
            dvd_in  = {dvd_ff[SQSUM_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               step_in  = '0;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      sqsum_ff <= sqsum_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      mean_ff  <= mean_in;
      rrem_ff  <= rrem_in;
      root_ff  <= root_in;
   end

endmodule

FILE: design/hes_back.sv
// back end: accumulates statistics, emits point words and set summaries
module hes_back #(
   parameter int MAX_POINTS = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fifo_empty,
   input  hes_pkg::point_type                   fifo_data,
   output logic                                 fifo_pop,
   output logic                                 rsp_result_kind,
   output logic signed [hes_pkg::ERR_W-1:0]     rsp_height_error,
   output logic                                 rsp_error_valid,
   output logic signed [hes_pkg::ERR_W-1:0]     rsp_mean_error,
   output logic signed [hes_pkg::ERR_W-1:0]     rsp_min_error,
   output logic signed [hes_pkg::ERR_W-1:0]     rsp_max_error,
   output logic [hes_pkg::RMS_W-1:0]            rsp_rms_error,
   output logic [hes_pkg::CNT_OUT_W-1:0]        rsp_valid_count,
   output logic                                 rsp_no_valid_points,
   output logic                                 rsp_last_result,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop
);
   import hes_pkg::*;
   `include "height_error_statistics_defines.svh"

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SUM_W = ERR_W + CNT_W;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_START,
      ST_CALC,
      ST_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQSUM_W-1:0]        sq_ff, sq_in;
   err_type                   min_ff, min_in;
   err_type                   max_ff, max_in;
   logic                      start_ff, start_in;

   logic                      out_v_ff, out_v_in;
   kind_type                  kind_ff, kind_in;
   err_type                   herr_ff, herr_in;
   logic                      ev_ff, ev_in;
   err_type                   mean_ff, mean_in;
   err_type                   omin_ff, omin_in;
   err_type                   omax_ff, omax_in;
   logic [RMS_W-1:0]          rms_ff, rms_in;
   logic [CNT_OUT_W-1:0]      ocnt_ff, ocnt_in;
   logic                      nv_ff, nv_in;
   logic                      lr_ff, lr_in;

   logic                      out_free;
   logic [SQSUM_W:0]          sq_add;
   logic                      sum_done;
   err_type                   sum_mean;
   logic [RMS_W-1:0]          sum_rms;

   hes_summary #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_summary (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .err_sum (sum_ff),
      .sq_sum  (sq_ff),
      .count   (cnt_ff),
      .done    (sum_done),
      .mean    (sum_mean),
      .rms     (sum_rms)
   );

   assign out_free = !out_v_ff || rsp_pop;
   assign sq_add   = {1'b0, sq_ff} + (SQSUM_W + 1)'(fifo_data.sq);

   // result word ports
   assign rsp_empty           = !out_v_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_height_error    = herr_ff;
   assign rsp_error_valid     = ev_ff;
   assign rsp_mean_error      = mean_ff;
   assign rsp_min_error       = omin_ff;
   assign rsp_max_error       = omax_ff;
   assign rsp_rms_error       = rms_ff;
   assign rsp_valid_count     = ocnt_ff;
   assign rsp_no_valid_points = nv_ff;
   assign rsp_last_result     = lr_ff;

   // sequencing, accumulation and output word selection
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      start_in = 1'b0;
      out_v_in = out_v_ff;
      kind_in  = kind_ff;
      herr_in  = herr_ff;
      ev_in    = ev_ff;
      mean_in  = mean_ff;
      omin_in  = omin_ff;
      omax_in  = omax_ff;
      rms_in   = rms_ff;
      ocnt_in  = ocnt_ff;
      nv_in    = nv_ff;
      lr_in    = lr_ff;
      fifo_pop = 1'b0;
      if (out_v_ff && rsp_pop) begin
         out_v_in = 1'b0;
      end
      unique case (state_ff)
         ST_RUN: begin
            if (!fifo_empty && out_free) begin
               fifo_pop = 1'b1;
               out_v_in = 1'b1;
               kind_in  = KIND_POINT;
               herr_in  = fifo_data.err;
               ev_in    = fifo_data.valid;
               mean_in  = '0;
               omin_in  = '0;
               omax_in  = '0;
               rms_in   = '0;
               ocnt_in  = '0;
               nv_in    = 1'b0;
               lr_in    = !fifo_data.last;
               if (fifo_data.valid && cnt_ff < CNT_W'(MAX_POINTS)) begin
                  cnt_in = cnt_ff + 1'b1;
                  sum_in = sum_ff + SUM_W'(fifo_data.err);
                  sq_in  = sq_add[SQSUM_W] ? '1 : sq_add[SQSUM_W-1:0];
                  if (cnt_ff == '0) begin
                     min_in = fifo_data.err;
                     max_in = fifo_data.err;
                  end else begin
                     if (fifo_data.err < min_ff) begin
                        min_in = fifo_data.err;
                     end
                     if (fifo_data.err > max_ff) begin
                        max_in = fifo_data.err;
                     end
                  end
               end
               if (fifo_data.last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               start_in = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (sum_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_v_in = 1'b1;
               kind_in  = KIND_SUMMARY;
               herr_in  = '0;
               ev_in    = 1'b0;
               lr_in    = 1'b1;
               if (cnt_ff == '0) begin
                  nv_in   = 1'b1;
                  mean_in = '0;
                  omin_in = '0;
                  omax_in = '0;
                  rms_in  = '0;
                  ocnt_in = '0;
               end else begin
                  nv_in   = 1'b0;
                  mean_in = sum_mean;
                  omin_in = min_ff;
                  omax_in = max_ff;
                  rms_in  = sum_rms;
                  ocnt_in = CNT_OUT_W'(cnt_ff);
               end
               cnt_in   = '0;
               sum_in   = '0;
               sq_in    = '0;
               min_in   = '0;
               max_in   = '0;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // state, accumulators and the output word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         start_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         start_ff <= start_in;
         out_v_ff <= out_v_in;
      end
      kind_ff <= kind_in;
      herr_ff <= herr_in;
      ev_ff   <= ev_in;
      mean_ff <= mean_in;
      omin_ff <= omin_in;
      omax_ff <= omax_in;
      rms_ff  <= rms_in;
      ocnt_ff <= ocnt_in;
      nv_ff   <= nv_in;
      lr_ff   <= lr_in;
   end

   // points are only drawn from the queue while no summary is pending
   `HES_ASSERT_IMPLY(a_pop_only_in_run, clock, reset, fifo_pop, state_ff == ST_RUN)
   // the count never passes its limit
   `HES_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_POINTS))
   // accumulators are empty once a summary word has been loaded
   `HES_ASSERT_NEXT(a_clear_after_summary, clock, reset, state_ff == ST_EMIT && out_free, cnt_ff == '0 && sum_ff == '0 && sq_ff == '0)
   // an empty set reports a zero count
   `HES_ASSERT_IMPLY(a_empty_set_zero, clock, reset, out_v_ff && kind_ff == KIND_SUMMARY && nv_ff, ocnt_ff == '0 && mean_ff == '0)

endmodule

FILE: design/height_error_statistics.sv
// height error statistics: per point errors and set summaries of model heights
//
// Input channel (req_): one word per check point, taken when req_push is high
// and req_full is low. A word carries the reference and model heights, the
// model valid flag and the last point mark.
// Result channel (rsp_): the oldest result word waits on the rsp_ ports while
// rsp_empty is low and leaves on a cycle with rsp_pop high.
// Every point gives one word with its error; a last point gives a second word,
// the set summary (mean, rms, min, max, count), after which the sums clear.
// A point word passes the front stages, the queue and the output register to the
// rsp_ ports. Points stream at one word per cycle while no summary is pending and
// the receiver pops. A summary follows its point word after two 64 step restoring
// divisions and a 32 step square root in the shared unit; points queue meanwhile.
// Reset is synchronous and clears all control state and the accumulators.
// When the receiver stalls, the output register holds its word, the queue fills
// and req_full rises; no word is lost.
module height_error_statistics #(
   parameter int MAX_POINTS  = 65536,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [hes_pkg::HT_W-1:0]      req_check_height,
   input  logic signed [hes_pkg::HT_W-1:0]      req_model_height,
   input  logic                                 req_model_valid,
   input  logic                                 req_last_point,
   input  logic                                 req_push,
   output logic                                 req_full,
   output logic                                 rsp_result_kind,
   output logic signed [hes_pkg::ERR_W-1:0]     rsp_height_error,
   output logic                                 rsp_error_valid,
   output logic signed [hes_pkg::ERR_W-1:0]     rsp_mean_error,
   output logic signed [hes_pkg::ERR_W-1:0]     rsp_min_error,
   output logic signed [hes_pkg::ERR_W-1:0]     rsp_max_error,
   output logic [hes_pkg::RMS_W-1:0]            rsp_rms_error,
   output logic [hes_pkg::CNT_OUT_W-1:0]        rsp_valid_count,
   output logic                                 rsp_no_valid_points,
   output logic                                 rsp_last_result,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop
);
   import hes_pkg::*;

   logic         push, fifo_full, fifo_pop, fifo_empty;
   point_type    push_data, fifo_data;

   // classify and square
   hes_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_check_height (req_check_height),
      .req_model_height (req_model_height),
      .req_model_valid  (req_model_valid),
      .req_last_point   (req_last_point),
      .req_push         (req_push),
      .req_full         (req_full),
      .push             (push),
      .push_data        (push_data),
      .fifo_full        (fifo_full)
   );

   // decoupling queue
   hes_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_data),
      .empty     (fifo_empty)
   );

   // accumulate and report
   hes_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .fifo_empty          (fifo_empty),
      .fifo_data           (fifo_data),
      .fifo_pop            (fifo_pop),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_height_error    (rsp_height_error),
      .rsp_error_valid     (rsp_error_valid),
      .rsp_mean_error      (rsp_mean_error),
      .rsp_min_error       (rsp_min_error),
      .rsp_max_error       (rsp_max_error),
      .rsp_rms_error       (rsp_rms_error),
      .rsp_valid_count     (rsp_valid_count),
      .rsp_no_valid_points (rsp_no_valid_points),
      .rsp_last_result     (rsp_last_result),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop)
   );

endmodule
